// ----- rtl/semt_pkg.sv -----
// Package for the sorted extent map table: sizes, codes and the types
// shared by the cell row and the top level. No dependencies.
package semt_pkg;

  localparam int NUM_CELLS = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam logic [14:0] MAX_RUN = 15'h7fff;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_MERGED   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [31:0] logical;
    logic [47:0] physical;
    logic [14:0] length;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_DOWN  = 2'd2,
    CMD_UP    = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] target;
    entry_t           wdata;
  } cell_cmd_t;

  typedef struct packed {
    logic nz;
    logic le;
    logic lt;
    logic gt;
    logic hit;
    logic lmatch;
    logic rmatch;
    logic sumok;
  } cell_flags_t;

endpackage

// ----- rtl/semt_cell.sv -----
// One extent cell: holds one entry, compares it against the current item
// and shifts from a neighbor on command. Depends on semt_pkg.
module semt_cell (
  input  logic                   clk,
  input  logic [semt_pkg::IDX_W-1:0] idx,
  input  semt_pkg::cell_cmd_t    cmd,
  input  logic [31:0]            key,
  input  logic [47:0]            ps,
  input  logic [14:0]            inlen,
  input  semt_pkg::entry_t       lower,
  input  semt_pkg::entry_t       upper,
  output semt_pkg::entry_t       ent,
  output semt_pkg::cell_flags_t  flags
);
  import semt_pkg::*;

  logic [32:0] end_l;
  logic [48:0] end_p;
  logic [32:0] key_end;
  logic [48:0] ps_end;
  logic [15:0] lsum;
  cell_flags_t flags_next;

  always_comb begin
    end_l = {1'b0, ent.logical} + {18'd0, ent.length};
    end_p = {1'b0, ent.physical} + {34'd0, ent.length};
    key_end = {1'b0, key} + {18'd0, inlen};
    ps_end = {1'b0, ps} + {34'd0, inlen};
    lsum = {1'b0, ent.length} + {1'b0, inlen};
    flags_next.nz = ent.length != 15'd0;
    flags_next.le = ent.logical <= key;
    flags_next.lt = ent.logical < key;
    flags_next.gt = ent.logical > key;
    flags_next.hit = (ent.length != 15'd0) && (ent.logical <= key) && ({1'b0, key} < end_l);
    flags_next.lmatch = (end_l == {1'b0, key}) && (end_p == {1'b0, ps});
    flags_next.rmatch = (key_end == {1'b0, ent.logical}) && (ps_end == {1'b0, ent.physical});
    flags_next.sumok = lsum <= {1'b0, MAX_RUN};
  end

  always_ff @(posedge clk) begin
    flags <= flags_next;
    if (cmd.kind != CMD_NONE) begin
      if (idx == cmd.target) begin
        ent <= cmd.wdata;
      end else if (idx > cmd.target) begin
        if (cmd.kind == CMD_DOWN) begin
          ent <= upper;
        end else if (cmd.kind == CMD_UP) begin
          ent <= lower;
        end
      end
    end
  end

endmodule

// ----- rtl/sorted_extent_map_table_top.sv -----
// Top level of the sorted extent map table: command decode, count and
// capacity, and the row of semt_cell instances. Depends on semt_pkg.
//
// Every item passes through S_CMP, in which all cells compare their entry
// against the item in parallel, and then S_UPD, in which the decision is made and
// the cells write, shift up or shift down together. busy is high through both
// states; done marks the result for one cycle after that and cannot be
// held off, so a new item may start in the cycle that done is shown.
module sorted_extent_map_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] logical_block,
  input  logic [47:0] physical_start,
  input  logic [14:0] run_length,
  input  logic        capacity_we,
  input  logic [4:0]  capacity,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  entry_index,
  output logic signed [4:0] pred_index,
  output logic [47:0] mapped_block,
  output logic [14:0] remaining
);
  import semt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t state;
  logic [4:0] cap_reg;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0] act_r;
  logic [31:0] key_r;
  logic [47:0] ps_r;
  logic [14:0] len_r;

  entry_t ents [NUM_CELLS];
  cell_flags_t flg [NUM_CELLS];
  cell_cmd_t cmd;

  logic [2:0] st_n;
  logic [IDX_W-1:0] idx_n;
  logic [4:0] prev_n;
  logic [47:0] blk_n;
  logic [14:0] rem_n;

  genvar g;
  generate
    for (g = 0; g < NUM_CELLS; g++) begin : g_cell
      entry_t lo_e;
      entry_t up_e;
      if (g == 0) begin : g_lo0
        assign lo_e = ents[g];
      end else begin : g_lo
        assign lo_e = ents[g-1];
      end
      if (g == NUM_CELLS - 1) begin : g_upn
        assign up_e = ents[g];
      end else begin : g_up
        assign up_e = ents[g+1];
      end
      semt_cell u_cell (
        .clk(clk), .idx(IDX_W'(g)), .cmd(cmd), .key(key_r), .ps(ps_r),
        .inlen(len_r), .lower(lo_e), .upper(up_e), .ent(ents[g]), .flags(flg[g])
      );
    end
  endgenerate

  logic found;
  logic [IDX_W-1:0] first;
  logic have_less;
  logic [IDX_W-1:0] below_idx;
  logic have_le;
  logic [IDX_W-1:0] last_le;
  logic [CNT_W-1:0] pos;
  logic [IDX_W-1:0] l_i;
  logic [IDX_W-1:0] r_i;
  logic [CNT_W-1:0] lim;
  logic [31:0] off;
  logic [15:0] lsum;
  logic [16:0] fsum;
  logic [15:0] rsum;
  logic left_ok;
  logic right_ok;
  logic fold_ok;

  always_comb begin
    found = 1'b0;
    first = '0;
    have_less = 1'b0;
    below_idx = '0;
    have_le = 1'b0;
    last_le = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (CNT_W'(i) < count) begin
        if (!found && flg[i].nz && (flg[i].hit || flg[i].gt)) begin
          found = 1'b1;
          first = IDX_W'(i);
        end
        if (!found && flg[i].nz && flg[i].lt) begin
          have_less = 1'b1;
          below_idx = IDX_W'(i);
        end
        if (flg[i].le) begin
          have_le = 1'b1;
          last_le = IDX_W'(i);
        end
      end
    end
    pos = have_le ? {1'b0, last_le} + CNT_W'(1) : '0;
    l_i = last_le;
    r_i = pos[IDX_W-1:0];
    lim = (cap_reg < CNT_W'(NUM_CELLS)) ? cap_reg : CNT_W'(NUM_CELLS);
    off = key_r - ents[first].logical;
    lsum = {1'b0, ents[l_i].length} + {1'b0, len_r};
    fsum = {1'b0, lsum} + {2'b0, ents[r_i].length};
    rsum = {1'b0, ents[r_i].length} + {1'b0, len_r};
    left_ok = have_le && flg[l_i].lmatch && flg[l_i].sumok;
    fold_ok = (pos < count) && flg[r_i].rmatch && (fsum <= {2'b0, MAX_RUN});
    right_ok = (pos < count) && flg[r_i].rmatch && flg[r_i].sumok;

    st_n = ST_MISS;
    idx_n = '0;
    prev_n = 5'h1f;
    blk_n = '0;
    rem_n = '0;
    count_next = count;
    cmd.kind = CMD_NONE;
    cmd.target = '0;
    cmd.wdata = ents[l_i];

    unique case (action_t'(act_r))
      ACT_LOOKUP: begin
        if (found && flg[first].hit) begin
          st_n = ST_HIT;
          idx_n = first;
          prev_n = {1'b0, first} - 5'd1;
          blk_n = ents[first].physical + {16'd0, off};
          rem_n = ents[first].length - off[14:0];
        end else if (have_less) begin
          prev_n = {1'b0, below_idx};
        end
      end
      ACT_INSERT: begin
        if (count > lim) begin
          st_n = ST_FULL;
        end else if (left_ok) begin
          st_n = ST_MERGED;
          idx_n = l_i;
          prev_n = {1'b0, l_i} - 5'd1;
          cmd.target = l_i;
          cmd.wdata = ents[l_i];
          blk_n = ents[l_i].physical;
          if (fold_ok) begin
            cmd.kind = CMD_DOWN;
            cmd.wdata.length = fsum[14:0];
            count_next = count - CNT_W'(1);
          end else begin
            cmd.kind = CMD_WRITE;
            cmd.wdata.length = lsum[14:0];
          end
          rem_n = cmd.wdata.length;
        end else if (right_ok) begin
          st_n = ST_MERGED;
          idx_n = r_i;
          prev_n = {1'b0, r_i} - 5'd1;
          cmd.kind = CMD_WRITE;
          cmd.target = r_i;
          cmd.wdata.logical = key_r;
          cmd.wdata.physical = ps_r;
          cmd.wdata.length = rsum[14:0];
          blk_n = ps_r;
          rem_n = rsum[14:0];
        end else if (count >= lim) begin
          st_n = ST_FULL;
        end else begin
          st_n = ST_INSERTED;
          idx_n = r_i;
          prev_n = pos - 5'd1;
          cmd.kind = CMD_UP;
          cmd.target = r_i;
          cmd.wdata.logical = key_r;
          cmd.wdata.physical = ps_r;
          cmd.wdata.length = len_r;
          blk_n = ps_r;
          rem_n = len_r;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_CLEAR: begin
        st_n = ST_FULL;
        count_next = '0;
      end
      ACT_NONE: begin
        st_n = ST_MISS;
      end
      default: begin
        st_n = ST_MISS;
      end
    endcase
    if (state != S_UPD) begin
      cmd.kind = CMD_NONE;
      count_next = count;
    end
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cap_reg <= 5'd4;
      count <= '0;
      done <= 1'b0;
    end else begin
      if (capacity_we) begin
        cap_reg <= capacity;
      end
      count <= count_next;
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_IDLE;
          done <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r <= action;
      key_r <= logical_block;
      ps_r <= physical_start;
      len_r <= run_length;
    end
    if (state == S_UPD) begin
      status <= st_n;
      entry_index <= idx_n;
      pred_index <= prev_n;
      mapped_block <= blk_n;
      remaining <= rem_n;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_CELLS)) else $error("entry count beyond cell row");
  a_done_after_upd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPD)) else $error("done without update cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_UPD) |=> $stable(count)) else $error("count changed outside update");

endmodule
